[hw/rtl/tsr_pkg.sv]
// tsr_pkg: shared types, widths, codes and reset values for the touch stroke recorder
// no dependencies; imported by the channel interfaces and all tsr modules

package tsr_pkg;

   localparam int DEF_MAX_POINTS = 512;

   localparam int OPCODE_W    = 4;
   localparam int COORD_W     = 12;
   localparam int INDEX_W     = 9;
   localparam int COUNT_OUT_W = 10;
   localparam int HEADER_W    = 16;
   localparam int WORD_W      = 2 * COORD_W;
   localparam int COUNT_EXT_W = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic                   ENABLE_RESET     = 1'b1;
   localparam logic [COORD_W-1:0]     DEADBAND_RESET   = 12'd5;
   localparam logic [COUNT_OUT_W-1:0] MIN_POINTS_RESET = 10'd32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SLOT        = 4'd0,
      OP_RELEASE     = 4'd1,
      OP_POS_X       = 4'd2,
      OP_POS_Y       = 4'd3,
      OP_BLANK       = 4'd4,
      OP_UNBLANK     = 4'd5,
      OP_READ_COUNT  = 4'd6,
      OP_READ_POINT  = 4'd7,
      OP_READ_FINISH = 4'd8,
      OP_OTHER       = 4'd9
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE        = 2'd0,
      CSR_MOVE_DEADBAND = 2'd1,
      CSR_MIN_POINTS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                   trigger;
      logic [COUNT_OUT_W-1:0] point_count;
      logic [HEADER_W-1:0]    header;
      logic                   rd_hit;
   } result_type;

endpackage

[hw/rtl/tsr_if.sv]
// tsr_if: request and response channel interfaces with valid/ready handshake
// depends on tsr_pkg for field widths

interface tsr_req_if import tsr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  value;
   logic [INDEX_W-1:0]  index;

   modport source (output valid, output opcode, output value, output index, input ready);
   modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

interface tsr_rsp_if import tsr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   trigger;
   logic [COUNT_OUT_W-1:0] point_count;
   logic [HEADER_W-1:0]    header;
   logic [WORD_W-1:0]      point_word;

   modport source (output valid, output trigger, output point_count, output header,
                   output point_word, input ready);
   modport sink   (input valid, input trigger, input point_count, input header,
                   input point_word, output ready);
endinterface

[hw/rtl/tsr_point_mem.sv]
// tsr_point_mem: point store, one write and one registered read per cycle
// depends on tsr_pkg for the point word width

module tsr_point_mem import tsr_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   localparam int ADDR_W = $clog2(MAX_POINTS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] point_mem_ff [MAX_POINTS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= point_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tsr_state.sv]
// tsr_state: configuration registers, stroke state and per-transaction update
// depends on tsr_pkg; drives the point store write and read addresses

module tsr_state import tsr_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   localparam int ADDR_W = $clog2(MAX_POINTS),
   localparam int CNT_W  = $clog2(MAX_POINTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   accept,
   input  logic [OPCODE_W-1:0]    opcode,
   input  logic [COORD_W-1:0]     value,
   input  logic [INDEX_W-1:0]     index,
   output result_type             res,
   output logic                   mem_wr_en,
   output logic [ADDR_W-1:0]      mem_wr_addr,
   output logic [WORD_W-1:0]      mem_wr_data,
   output logic [ADDR_W-1:0]      mem_rd_addr
);

   localparam logic [CNT_W-1:0]       MaxCount = CNT_W'(MAX_POINTS);
   localparam logic [COUNT_EXT_W-1:0] MaxExt   = COUNT_EXT_W'(MAX_POINTS);

   logic                   enable_ff, enable_in;
   logic [COORD_W-1:0]     deadband_ff, deadband_in;
   logic [COUNT_OUT_W-1:0] min_points_ff, min_points_in;

   logic               blanked_ff, blanked_in;
   logic               locked_ff, locked_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [COORD_W-1:0] cur_y_ff, cur_y_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in;
   logic [COORD_W-1:0] last_y_ff, last_y_in;

   logic                   touch_ok;
   logic [COORD_W-1:0]     new_x, new_y;
   logic                   first_point, moved, can_store, do_store;
   logic [COUNT_EXT_W-1:0] count_ext, count_next_ext;
   logic [7:0]             count_hi;
   logic                   trig;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // configuration
   always_comb begin
      enable_in     = enable_ff;
      deadband_in   = deadband_ff;
      min_points_in = min_points_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:        enable_in     = csr_wdata[0];
            CSR_MOVE_DEADBAND: deadband_in   = csr_wdata;
            CSR_MIN_POINTS:    min_points_in = csr_wdata[COUNT_OUT_W-1:0];
            default:           ;
         endcase
      end
   end

   // point logging decision for position transactions
   assign touch_ok   = enable_ff & blanked_ff;
   assign new_x      = (op_type'(opcode) == OP_POS_X) ? value : cur_x_ff;
   assign new_y      = (op_type'(opcode) == OP_POS_Y) ? value : cur_y_ff;
   assign first_point = (count_ff == '0);
   assign moved      = (abs_diff(new_x, last_x_ff) > deadband_ff) |
                       (abs_diff(new_y, last_y_ff) > deadband_ff);
   assign can_store  = (count_ff < MaxCount) & ~locked_ff;
   assign count_ext  = COUNT_EXT_W'(count_ff);

   always_comb begin
      blanked_in = blanked_ff;
      locked_in  = locked_ff;
      count_in   = count_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      do_store   = 1'b0;
      trig       = 1'b0;
      if (accept) begin
         case (op_type'(opcode))
            OP_SLOT: begin
               if (touch_ok && !locked_ff) begin
                  count_in = '0;
               end
            end
            OP_RELEASE: begin
               if (touch_ok) begin
                  if (count_ext >= COUNT_EXT_W'(min_points_ff)) begin
                     trig      = 1'b1;
                     locked_in = 1'b1;
                  end else if (!locked_ff) begin
                     count_in = '0;
                  end
               end
            end
            OP_POS_X, OP_POS_Y: begin
               if (touch_ok) begin
                  cur_x_in = new_x;
                  cur_y_in = new_y;
                  do_store = (first_point | moved) & can_store;
                  if (first_point || do_store) begin
                     last_x_in = new_x;
                     last_y_in = new_y;
                  end
                  if (do_store) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
            OP_BLANK: begin
               blanked_in = 1'b1;
            end
            OP_UNBLANK: begin
               blanked_in = 1'b0;
               if (!locked_ff) begin
                  count_in = '0;
               end
            end
            OP_READ_FINISH: begin
               locked_in = 1'b0;
               count_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // result fields
   assign count_next_ext = COUNT_EXT_W'(count_in);
   assign count_hi       = count_ext[15:8];

   always_comb begin
      res             = '0;
      res.trigger     = trig;
      res.point_count = count_next_ext[COUNT_OUT_W-1:0];
      if (op_type'(opcode) == OP_READ_COUNT) begin
         res.header = {((count_hi != 8'd0) ? count_hi : 8'hff), count_ext[7:0]};
      end
      if (op_type'(opcode) == OP_READ_POINT) begin
         res.rd_hit = (COUNT_EXT_W'(index) < count_ext) && (COUNT_EXT_W'(index) < MaxExt);
      end
   end

   assign mem_wr_en   = do_store;
   assign mem_wr_addr = ADDR_W'(count_ff);
   assign mem_wr_data = {new_x, new_y};
   assign mem_rd_addr = ADDR_W'(index);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= ENABLE_RESET;
         deadband_ff   <= DEADBAND_RESET;
         min_points_ff <= MIN_POINTS_RESET;
         blanked_ff    <= 1'b0;
         locked_ff     <= 1'b0;
         count_ff      <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
      end else begin
         enable_ff     <= enable_in;
         deadband_ff   <= deadband_in;
         min_points_ff <= min_points_in;
         blanked_ff    <= blanked_in;
         locked_ff     <= locked_in;
         count_ff      <= count_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("point count beyond store depth");

   a_trigger_locks: assert property (@(posedge clock) disable iff (reset)
      accept && trig |=> locked_ff && count_ff == $past(count_ff))
      else $error("trigger did not lock the stroke");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("stored point not counted");

endmodule

[hw/rtl/touch_stroke_recorder_core.sv]
// Touch stroke recorder: takes one request transaction per clock unless a stalled response
// side holds it off, and returns one response transaction for each, registered in the s1
// stage and then in the response register. The state update and the point store write
// happen at acceptance; the store has a single write port and a single registered read
// port, which sets the extra pipeline stage that every response passes through, point
// read or not. Reading a point index at or above the logged count returns zero. Depends
// on tsr_pkg, tsr_if, tsr_state and tsr_point_mem.

module touch_stroke_recorder_core import tsr_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   tsr_req_if.sink                req_chan,
   tsr_rsp_if.source              rsp_chan
);

   localparam int ADDR_W = $clog2(MAX_POINTS);

   logic              accept;
   result_type        res;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   logic       s1_valid_ff, s1_valid_in;
   result_type s1_res_ff;
   logic       s1_adv;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_trigger_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [HEADER_W-1:0]    rsp_header_ff;
   logic [WORD_W-1:0]      rsp_word_ff;

   tsr_state #(.MAX_POINTS(MAX_POINTS)) u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .opcode      (req_chan.opcode),
      .value       (req_chan.value),
      .index       (req_chan.index),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr)
   );

   tsr_point_mem #(.MAX_POINTS(MAX_POINTS)) u_point_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign s1_adv         = s1_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | s1_adv;
   assign accept         = req_chan.valid & req_chan.ready;
   assign s1_valid_in    = accept | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in   = s1_adv | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= res;
      end
      if (s1_adv) begin
         rsp_trigger_ff <= s1_res_ff.trigger;
         rsp_count_ff   <= s1_res_ff.point_count;
         rsp_header_ff  <= s1_res_ff.header;
         rsp_word_ff    <= s1_res_ff.rd_hit ? mem_rd_data : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.trigger     = rsp_trigger_ff;
   assign rsp_chan.point_count = rsp_count_ff;
   assign rsp_chan.header      = rsp_header_ff;
   assign rsp_chan.point_word  = rsp_word_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost");

   a_adv_delivers: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced transaction not presented");

   a_header_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_header_ff != '0 |-> rsp_header_ff[15:8] != 8'd0)
      else $error("header high byte zero");

endmodule

[tb/tb.sv]
// tb: self-checking bench for touch_stroke_recorder_core, driving request transactions,
// predicting every response and comparing it field by field
// depends on tsr_pkg, tsr_if and the core rtl

module tb import tsr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 1000;
   localparam int TARGET_ITEMS = 1150;

   typedef struct packed {
      logic                   trigger;
      logic [COUNT_OUT_W-1:0] point_count;
      logic [HEADER_W-1:0]    header;
      logic [WORD_W-1:0]      point_word;
   } response_type;

   class stroke_model_type;
      bit                enable;
      int unsigned       deadband;
      int unsigned       min_points;
      bit                blanked;
      bit                locked;
      int unsigned       count;
      logic [COORD_W-1:0] cur_x, cur_y, last_x, last_y;
      logic [WORD_W-1:0] points [DEF_MAX_POINTS];
      response_type      expected_rsp [$];
      int                errors;

      function new();
         enable     = ENABLE_RESET;
         deadband   = DEADBAND_RESET;
         min_points = MIN_POINTS_RESET;
         blanked    = 1'b0;
         locked     = 1'b0;
         count      = 0;
         cur_x      = '0;
         cur_y      = '0;
         last_x     = '0;
         last_y     = '0;
         errors     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENABLE:        enable = data[0];
            CSR_MOVE_DEADBAND: deadband = data;
            CSR_MIN_POINTS:    min_points = data[COUNT_OUT_W-1:0];
            default: ;
         endcase
      endfunction

      function void clear_count();
         if (!locked) count = 0;
      endfunction

      function int unsigned distance(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void log_point();
         if (count >= DEF_MAX_POINTS || locked) return;
         points[count] = {cur_x, cur_y};
         count++;
         last_x = cur_x;
         last_y = cur_y;
      endfunction

      function void consider_point();
         if (count == 0) begin
            last_x = cur_x;
            last_y = cur_y;
            log_point();
         end else if (distance(cur_x, last_x) > deadband ||
                      distance(cur_y, last_y) > deadband) begin
            log_point();
         end
      endfunction

      function void note_event(logic [OPCODE_W-1:0] code, logic [COORD_W-1:0] val,
                               logic [INDEX_W-1:0] idx);
         response_type rsp;
         bit        touch_ok;
         logic [7:0] hi;
         rsp      = '0;
         touch_ok = enable && blanked;
         case (op_type'(code))
            OP_SLOT: if (touch_ok) clear_count();
            OP_RELEASE: if (touch_ok) begin
               if (count >= min_points) begin
                  locked      = 1'b1;
                  rsp.trigger = 1'b1;
               end
               clear_count();
            end
            OP_POS_X: if (touch_ok) begin
               cur_x = val;
               consider_point();
            end
            OP_POS_Y: if (touch_ok) begin
               cur_y = val;
               consider_point();
            end
            OP_BLANK: blanked = 1'b1;
            OP_UNBLANK: begin
               blanked = 1'b0;
               clear_count();
            end
            OP_READ_COUNT: begin
               hi         = 8'(count >> 8);
               rsp.header = {((hi != 8'd0) ? hi : 8'hff), 8'(count)};
            end
            OP_READ_POINT: if (idx < count) rsp.point_word = points[idx];
            OP_READ_FINISH: begin
               locked = 1'b0;
               clear_count();
            end
            default: ;
         endcase
         rsp.point_count = COUNT_OUT_W'(count);
         expected_rsp.push_back(rsp);
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (expected_rsp.size() == 0) begin
            $error("response transaction with none expected");
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.trigger !== want.trigger) begin
            $error("trigger: expected %0d, got %0d", want.trigger, got.trigger);
            errors++;
         end
         if (got.point_count !== want.point_count) begin
            $error("point_count: expected %0d, got %0d", want.point_count, got.point_count);
            errors++;
         end
         if (got.header !== want.header) begin
            $error("header: expected %h, got %h", want.header, got.header);
            errors++;
         end
         if (got.point_word !== want.point_word) begin
            $error("point_word: expected %h, got %h", want.point_word, got.point_word);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   calm = 1'b0;
   logic [COORD_W-1:0]     pen_x = '0;
   logic [COORD_W-1:0]     pen_y = '0;
   int                     sent = 0;
   int                     quiet = 0;
   stroke_model_type       model = new();

   tsr_req_if req_if ();
   tsr_rsp_if rsp_if ();

   touch_stroke_recorder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99) >= 21);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            model.note_event(req_if.opcode, req_if.value, req_if.index);
         if (rsp_if.valid && rsp_if.ready)
            model.check_response({rsp_if.trigger, rsp_if.point_count, rsp_if.header,
                                  rsp_if.point_word});
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send(logic [OPCODE_W-1:0] code, logic [COORD_W-1:0] val,
                       logic [INDEX_W-1:0] idx);
      while (!calm && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.opcode <= code;
      req_if.value  <= val;
      req_if.index  <= idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (code <= OP_READ_FINISH) sent++;
   endtask

   // drop valid and wait until every response transaction is back
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (model.expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model.set_register(idx, data);
      @(posedge clock);
   endtask

   task automatic configure(bit en, int band, int minp);
      write_reg(CSR_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_MOVE_DEADBAND, CSR_DATA_W'(band));
      write_reg(CSR_MIN_POINTS, CSR_DATA_W'(minp));
   endtask

   function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c, int band);
      int step;
      int v;
      case ($urandom_range(3))
         0: return COORD_W'($urandom_range(4095));
         1: step = $urandom_range(band);
         2: step = band + 1;
         default: step = $urandom_range(band + 8);
      endcase
      v = $urandom_range(1) ? int'(c) + step : int'(c) - step;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return COORD_W'(v);
   endfunction

   task automatic stroke(int moves, int band);
      int r;
      for (int i = 0; i < moves; i++) begin
         r = $urandom_range(99);
         if (r < 5) begin
            send(OPCODE_W'($urandom_range(15)), COORD_W'($urandom_range(4095)),
                 INDEX_W'($urandom_range(511)));
         end else if (r < 8) begin
            send(OP_SLOT, COORD_W'($urandom_range(4095)), INDEX_W'($urandom_range(511)));
         end else if ($urandom_range(1)) begin
            pen_x = nudge(pen_x, band);
            send(OP_POS_X, pen_x, INDEX_W'($urandom_range(511)));
         end else begin
            pen_y = nudge(pen_y, band);
            send(OP_POS_Y, pen_y, INDEX_W'($urandom_range(511)));
         end
      end
   endtask

   task automatic read_back(int n);
      int top;
      send(OP_READ_COUNT, COORD_W'($urandom_range(4095)), INDEX_W'($urandom_range(511)));
      repeat (n) begin
         top = (model.count + 1 > 511) ? 511 : model.count + 1;
         send(OP_READ_POINT, COORD_W'($urandom_range(4095)),
              ($urandom_range(4) == 0) ? INDEX_W'($urandom_range(511))
                                       : INDEX_W'($urandom_range(top)));
      end
   endtask

   task automatic session(int band);
      int moves;
      moves = ($urandom_range(3) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 20);
      if ($urandom_range(99) < 85) send(OP_BLANK, COORD_W'($urandom_range(4095)), '0);
      stroke(moves, band);
      send(OP_RELEASE, COORD_W'($urandom_range(4095)), INDEX_W'($urandom_range(511)));
      if ($urandom_range(99) < 70) read_back($urandom_range(1, 6));
      if ($urandom_range(99) < 60) send(OP_READ_FINISH, '0, INDEX_W'($urandom_range(511)));
      if ($urandom_range(99) < 30) send(OP_UNBLANK, COORD_W'($urandom_range(4095)), '0);
   endtask

   // fills the store past its capacity, then exercises the locked store
   task automatic full_stroke();
      send(OP_READ_FINISH, '0, '0);
      send(OP_BLANK, '0, '0);
      for (int i = 0; i < DEF_MAX_POINTS + 18; i++)
         send(i[0] ? OP_POS_Y : OP_POS_X, COORD_W'(i * 7 + 1), INDEX_W'($urandom_range(511)));
      send(OP_READ_COUNT, '0, '0);
      send(OP_RELEASE, '0, '0);
      send(OP_READ_POINT, '0, INDEX_W'(DEF_MAX_POINTS - 1));
      read_back(6);
      send(OP_POS_X, 12'd4000, '0);
      send(OP_SLOT, '0, '0);
      send(OP_RELEASE, '0, '0);
      send(OP_UNBLANK, '0, '0);
      send(OP_READ_COUNT, '0, '0);
      send(OP_READ_POINT, '0, INDEX_W'(DEF_MAX_POINTS - 1));
      send(OP_READ_FINISH, '0, '0);
      send(OP_READ_COUNT, '0, '0);
   endtask

   initial begin : stimulus
      int phase;
      int band;
      int minp;
      bit en;

      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_ENABLE;
      csr_wdata     <= '0;
      req_if.valid  <= 1'b0;
      req_if.opcode <= OP_OTHER;
      req_if.value  <= '0;
      req_if.index  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings, screen not yet blanked
      send(OP_POS_X, 12'd100, '0);
      send(OP_BLANK, '0, '0);
      send(OP_READ_COUNT, '0, '0);
      send(OP_POS_X, 12'd0, 9'd511);
      send(OP_POS_Y, 12'd4095, '0);
      send(OP_POS_X, 12'd4095, '0);
      send(OP_POS_X, 12'd4093, '0);
      send(OP_POS_Y, 12'd4089, '0);
      send(OP_READ_POINT, '0, 9'd0);
      send(OP_READ_POINT, '0, 9'd3);
      send(OP_READ_POINT, '0, 9'd4);
      send(OP_READ_POINT, 12'd4095, 9'd511);
      send(OP_RELEASE, '0, '0);
      send(OPCODE_W'($urandom_range(10, 15)), 12'd4095, 9'd511);
      send(OP_OTHER, '0, '0);
      send(OP_SLOT, '0, '0);
      send(OP_READ_FINISH, '0, '0);
      send(OP_UNBLANK, '0, '0);

      // zero minimum: release triggers with an empty store
      settle();
      configure(1'b1, 0, 0);
      send(OP_BLANK, '0, '0);
      send(OP_RELEASE, '0, '0);
      send(OP_POS_X, 12'd77, '0);
      send(OP_RELEASE, '0, '0);
      send(OP_READ_COUNT, '0, '0);
      send(OP_READ_FINISH, '0, '0);

      settle();
      configure(1'b0, 5, 32);
      send(OP_POS_X, 12'd1, '0);
      send(OP_RELEASE, '0, '0);
      send(OP_UNBLANK, '0, '0);

      phase = 0;
      while (sent < TARGET_ITEMS) begin
         settle();
         calm <= (phase == 3);
         if (phase == 1) begin
            configure(1'b1, 0, DEF_MAX_POINTS);
            full_stroke();
         end else begin
            en = ($urandom_range(9) != 0);
            case ($urandom_range(5))
               0: band = 0;
               1: band = 4095;
               2, 3: band = $urandom_range(20);
               4: band = $urandom_range(4095);
               default: band = $urandom_range(200);
            endcase
            case ($urandom_range(4))
               0: minp = 1;
               1: minp = DEF_MAX_POINTS;
               2: minp = $urandom_range(1, 40);
               default: minp = $urandom_range(1, 20);
            endcase
            configure(en, band, minp);
            repeat ($urandom_range(2, 5)) session(band);
         end
         phase++;
      end

      settle();
      if (model.errors == 0 && model.expected_rsp.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_if.sv
hw/rtl/tsr_point_mem.sv
hw/rtl/tsr_state.sv
hw/rtl/touch_stroke_recorder_core.sv
tb/tb.sv
